// File: rtl/binomial_coefficient_checked_defines.svh
// Assertion macros for the binomial coefficient block.
`ifndef BINOMIAL_COEFFICIENT_CHECKED_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_CHECKED_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/bcc_pkg.sv
// Shared types and constants for the binomial coefficient block.
`default_nettype none
package bcc_pkg;
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NNEG = 3'd1;
    localparam logic [2:0] ST_KNEG = 3'd2;
    localparam logic [2:0] ST_KGTN = 3'd3;
    localparam logic [2:0] ST_OVF  = 3'd4;
    localparam int unsigned KLIMIT = 34;
    localparam int DIV_W = 6;
endpackage
`default_nettype wire

// File: rtl/bcc_muldiv.sv
// Shared unit: 64x64 multiply in 32x32 partial products, then 128-step restoring divide.
`default_nettype none
module bcc_muldiv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    input  wire logic [bcc_pkg::DIV_W-1:0] divisor,
    output logic             done,
    output logic [127:0]     quotient
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [2:0]   cnt_reg;
    logic [6:0]   bit_reg;
    logic [63:0]  a_reg, b_reg;
    logic [127:0] prod_reg;
    logic [bcc_pkg::DIV_W:0] rem_reg;
    logic [bcc_pkg::DIV_W-1:0] d_reg;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [bcc_pkg::DIV_W:0] trial;
    logic [bcc_pkg::DIV_W+1:0] diff;

    // one partial product per cycle: index bit0 selects a half, bit1 selects b half
    assign pp = {32'd0, (cnt_reg[0] ? a_reg[63:32] : a_reg[31:0])}
              * {32'd0, (cnt_reg[1] ? b_reg[63:32] : b_reg[31:0])};
    assign pp_sh = {64'd0, pp} << (7'(cnt_reg[0]) * 7'd32 + 7'(cnt_reg[1]) * 7'd32);
    assign trial = {rem_reg[bcc_pkg::DIV_W-1:0], prod_reg[127]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_MUL;
            S_MUL:  if (cnt_reg == 3'd3) state_next = S_DIV;
            S_DIV:  if (bit_reg == 7'd127) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == S_DIV) && (bit_reg == 7'd127);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                d_reg    <= divisor;
                prod_reg <= '0;
                cnt_reg  <= '0;
            end
            S_MUL:
            begin
                prod_reg <= prod_reg + pp_sh;
                cnt_reg  <= cnt_reg + 3'd1;
                bit_reg  <= '0;
                rem_reg  <= '0;
            end
            S_DIV:
            begin
                // product shifts out the top, quotient bits shift in below
                if (!diff[bcc_pkg::DIV_W+1])
                begin
                    rem_reg  <= diff[bcc_pkg::DIV_W:0];
                    prod_reg <= {prod_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial;
                    prod_reg <= {prod_reg[126:0], 1'b0};
                end
                bit_reg <= bit_reg + 7'd1;
            end
            default: ;
        endcase
    end

    assign quotient = prod_reg;
endmodule
`default_nettype wire

// File: rtl/binomial_coefficient_checked.sv
// Top level: checked n choose k with a sequencer around one multiply/divide unit.
// Usage:
//  - Input channel in_valid/in_ready carries n_value and k_value (signed 64 bit).
//  - Output channel out_valid/out_ready carries coefficient (63 bit) and status.
//  - One item at a time: in_ready is high only while the block is idle.
//  - Error cases (n negative, k negative, k above n) and trivial cases (k of 0
//    or 1 after reflection, or reflected k of 34 and up, which overflows) finish
//    straight from the check state, with no iteration.
//  - Otherwise up to k-1 iterations (reflected k) run on the shared unit; each
//    runs 4 partial products, 128 restoring division steps and a handoff.
//    The worst case is k = 33; the one-bit divider sets the rate.
//  - The result is held in an output register until out_ready takes it; the
//    block stays busy while the receiver stalls.
//  - Reset (rst_n, async, active low) returns the sequencer to idle with no
//    result pending. There is no other state.
`default_nettype none
`include "binomial_coefficient_checked_defines.svh"
module binomial_coefficient_checked (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic signed [63:0] n_value,
    input  wire logic signed [63:0] k_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [62:0]      coefficient,
    output logic [2:0]       status
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  state_reg;
    logic [63:0] n_reg, k_reg, acc_reg;
    logic [5:0]  i_reg;
    logic [62:0] coef_reg;
    logic [2:0]  stat_reg;
    logic        unit_start, unit_done;
    logic [127:0] unit_q;
    logic [63:0] k_refl;
    logic        out_stall;
    logic [65:0] out_word;

    // reflect k to min(k, n-k)
    assign k_refl = (k_reg > (n_reg >> 1)) ? (n_reg - k_reg) : k_reg;
    assign unit_start = (state_reg == S_START);

    bcc_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .op_a     (acc_reg),
        .op_b     (n_reg + 64'd1 - {58'd0, i_reg}),
        .divisor  (i_reg),
        .done     (unit_done),
        .quotient (unit_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        n_reg     <= n_value;
                        k_reg     <= k_value;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    priority if (n_reg[63])
                    begin
                        stat_reg <= bcc_pkg::ST_NNEG; coef_reg <= '0; state_reg <= S_OUT;
                    end
                    else if (k_reg[63])
                    begin
                        stat_reg <= bcc_pkg::ST_KNEG; coef_reg <= '0; state_reg <= S_OUT;
                    end
                    else if (k_reg > n_reg)
                    begin
                        stat_reg <= bcc_pkg::ST_KGTN; coef_reg <= '0; state_reg <= S_OUT;
                    end
                    else if (k_refl == 64'd0)
                    begin
                        stat_reg <= bcc_pkg::ST_OK; coef_reg <= 63'd1; state_reg <= S_OUT;
                    end
                    else if (k_refl >= 64'(bcc_pkg::KLIMIT))
                    begin
                        stat_reg <= bcc_pkg::ST_OVF; coef_reg <= '0; state_reg <= S_OUT;
                    end
                    else if (k_refl == 64'd1)
                    begin
                        stat_reg <= bcc_pkg::ST_OK; coef_reg <= n_reg[62:0];
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        acc_reg   <= n_reg;
                        k_reg     <= k_refl;
                        i_reg     <= 6'd2;
                        state_reg <= S_START;
                    end
                end
                S_START: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (unit_done)
                    begin
                        if (unit_q[127:63] != '0)
                        begin
                            stat_reg <= bcc_pkg::ST_OVF; coef_reg <= '0; state_reg <= S_OUT;
                        end
                        else if ({58'd0, i_reg} == k_reg)
                        begin
                            stat_reg <= bcc_pkg::ST_OK; coef_reg <= unit_q[62:0];
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            acc_reg   <= unit_q[63:0];
                            i_reg     <= i_reg + 6'd1;
                            state_reg <= S_START;
                        end
                    end
                end
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign coefficient = coef_reg;
    assign status      = stat_reg;

    assign out_stall = out_valid && !out_ready;
    assign out_word  = {coefficient, status};

    `BC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (status != bcc_pkg::ST_OK), ~|coefficient)
    `BC_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `BC_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for binomial_coefficient_checked.
module tb_top;

    localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
    localparam int RANDOM_ITEMS = 1730;

    // Expected result of one item.
    typedef struct packed {
        logic [62:0] coef;
        logic [2:0]  code;
    } choose_result_t;

    // Holds the predicted n-choose-k results in acceptance order and
    // compares each returned result against the oldest one.
    class choose_scoreboard;
        choose_result_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Exact C(n,k) with range checks, computed the same way the block does.
        static function choose_result_t predict(logic [63:0] n, logic [63:0] k);
            choose_result_t r;
            logic [63:0]  kk;
            logic [127:0] acc;
            logic [127:0] prod;
            longint unsigned i;
            r.coef = '0;
            r.code = bcc_pkg::ST_OK;
            if (n[63])
                r.code = bcc_pkg::ST_NNEG;
            else if (k[63])
                r.code = bcc_pkg::ST_KNEG;
            else if (k > n)
                r.code = bcc_pkg::ST_KGTN;
            if (r.code != bcc_pkg::ST_OK)
                return r;
            kk = (k > (n >> 1)) ? n - k : k;
            if (kk == 0) begin
                r.coef = 63'd1;
            end else if (kk >= bcc_pkg::KLIMIT) begin
                r.code = bcc_pkg::ST_OVF;
            end else begin
                acc = {64'd0, n};
                for (i = 2; i <= kk; i++) begin
                    prod = acc * {64'd0, n + 64'd1 - i};
                    prod = prod / {64'd0, i};
                    if (prod[127:63] != '0) begin
                        r.code = bcc_pkg::ST_OVF;
                        acc = '0;
                        break;
                    end
                    acc = prod;
                end
                r.coef = acc[62:0];
            end
            return r;
        endfunction

        function void note_item(logic [63:0] n, logic [63:0] k);
            pending = {pending, predict(n, k)};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [62:0] coef, logic [2:0] code);
            choose_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result coef=%0d status=%0d", coef, code));
                return;
            end
            e = pending.pop_front();
            if (code !== e.code)
                report($sformatf("status %0d, expected %0d", code, e.code));
            if (coef !== e.coef)
                report($sformatf("coefficient %0d, expected %0d", coef, e.coef));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [63:0] n_value = '0;
    logic signed [63:0] k_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [62:0] coefficient;
    logic [2:0]  status;

    choose_scoreboard board = new();
    longint unsigned cycles = 0;
    int send_idle_pct = 22;     // sender idle chance per slot, percent
    int recv_stall_pct = 76;    // receiver stall chance per cycle, percent
    bit long_holdoff = 1'b0;    // receiver parks out_ready low while set

    binomial_coefficient_checked uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .n_value(n_value), .k_value(k_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .coefficient(coefficient), .status(status)
    );

    always #5 clk = ~clk;

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off while long_holdoff is set.
    always @(posedge clk)
    begin
        if (!rst_n || long_holdoff)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor; values seen here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(coefficient, status);
    end

    // Offer one item and hold it until the block takes it. Valid stays high
    // on return so back-to-back items need no second assignment in one step.
    task send_item(logic [63:0] n, logic [63:0] k);
        in_valid <= 1'b1;
        n_value <= n;
        k_value <= k;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        board.note_item(n, k);
    endtask

    // Random sender gap: sometimes drop valid before the next item.
    task maybe_idle();
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random item: mostly small n and k so the one-bit divider stays cheap,
    // with error cases, full-width values, reflection and rare large k.
    task random_item();
        logic [63:0] n;
        logic [63:0] k;
        int sel;
        sel = $urandom_range(99);
        n = {$urandom, $urandom};
        k = {$urandom, $urandom};
        if (sel < 20)
        begin
            // any pair, mostly errors, full 64-bit patterns
        end
        else if (sel < 30)
        begin
            // full-width n with trivial or edge k
            n[63] = 1'b0;
            case ($urandom_range(3))
                0: k = 0;
                1: k = 1;
                2: k = n;
                default: k = n - 1;
            endcase
        end
        else if (sel < 45)
        begin
            // wide n, small k, sometimes reflected: may overflow or fit
            n = {$urandom, $urandom} >> $urandom_range(1, 60);
            k = $urandom_range(0, 5);
            if ($urandom_range(1))
                k = n - k;
        end
        else if (sel < 98)
        begin
            // well-formed small problems, sometimes reflected
            n = $urandom_range(0, 200);
            k = $urandom_range(0, 6);
            if (k > n)
                k = n;
            if ($urandom_range(3) == 0)
                k = n - k;
        end
        else
        begin
            // deep iteration near the overflow boundary
            k = $urandom_range(20, 33);
            n = $urandom_range(2 * k, 75);
            if ($urandom_range(1))
                k = n - k;
        end
        send_item(n, k);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: status priority, extremes, reflection, boundaries.
        send_item(-64'sd1, 64'sd0);
        send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_item(-64'sd5, 64'sd9);
        send_item(64'sd5, -64'sd1);
        send_item(64'sd5, 64'h8000_0000_0000_0000);
        send_item(64'sd5, 64'sd6);
        send_item(64'sd5, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(64'sd0, 64'sd0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'sd0);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'sd1);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE);
        send_item(64'h7FFF_FFFF_FFFF_FFFF, 64'sd2);
        send_item(64'sd10, 64'sd7);
        send_item(64'sd66, 64'sd33);      // largest central value that fits
        send_item(64'sd67, 64'sd33);      // just past 2^63-1
        send_item(64'sd68, 64'sd34);      // reflected k at the KLIMIT bound
        send_item(64'sd1000, 64'sd500);
        send_item(64'sd62, 64'sd31);
        send_item(64'h1_0000_0000, 64'sd2);
        send_item(64'h1_0000_0001, 64'sd2);
        send_item(64'sd1, 64'sd1);

        // Pressure: stall the receiver long enough for the block to
        // back up and hold in_ready low while the sender keeps offering.
        long_holdoff = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                long_holdoff = 1'b0;
            end
            begin
                repeat (4) random_item();
            end
        join
        // Sender pause until every result is back.
        wait_drained();

        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            if (idx == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 76;
                recv_stall_pct = 22;
            end
            else if (idx == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            maybe_idle();
            random_item();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
